@@ rtl/core/binary_confusion_metrics_core_assert.svh @@
// assertion macros used by the checker file of the confusion metrics core
// no dependencies; included by bare file name
`ifndef BINARY_CONFUSION_METRICS_CORE_ASSERT_SVH
`define BINARY_CONFUSION_METRICS_CORE_ASSERT_SVH

// same-cycle implication
`define BCM_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("confusion metrics core check failed");

// next-cycle implication
`define BCM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("confusion metrics core check failed");

`endif

@@ rtl/core/bcm_pkg.sv @@
// types, constants and codes of the binary confusion metrics core
// no dependencies; used by every module of the core
package bcm_pkg;

   localparam int SAMPLE_BITS = 16;
   localparam int MAX_SAMPLES = 65536;
   localparam int QUEUE_DEPTH = 4;
   localparam int OUT_W       = 17;
   localparam int FRAC_BITS   = 16;

   localparam logic signed [SAMPLE_BITS-1:0] THRESH_RESET = SAMPLE_BITS'(2048);
   localparam logic signed [SAMPLE_BITS-1:0] TARGET_HALF  = SAMPLE_BITS'(2048);
   localparam logic [OUT_W-1:0]              RATIO_ONE    = OUT_W'(1 << FRAC_BITS);

   typedef enum logic [1:0] {
      CLS_TP,
      CLS_FP,
      CLS_FN,
      CLS_TN
   } bcm_class_type;

   typedef enum logic [1:0] {
      RAT_PREC,
      RAT_REC,
      RAT_F1,
      RAT_ACC
   } bcm_ratio_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOAD,
      ST_WAIT,
      ST_SEND
   } bcm_state_type;

   typedef struct packed {
      bcm_class_type cls;
      logic          last;
   } bcm_entry_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] prediction;
      logic signed [SAMPLE_BITS-1:0] target;
      logic                          last_sample;
   } bcm_req_type;

   typedef struct packed {
      logic [OUT_W-1:0] true_pos;
      logic [OUT_W-1:0] false_pos;
      logic [OUT_W-1:0] false_neg;
      logic [OUT_W-1:0] true_neg;
      logic [OUT_W-1:0] precision_ratio;
      logic [OUT_W-1:0] recall_ratio;
      logic [OUT_W-1:0] f1_ratio;
      logic [OUT_W-1:0] accuracy_ratio;
   } bcm_rsp_type;

endpackage

@@ rtl/core/bcm_fifo.sv @@
// short queue of classified requests between front and back end
// depends on bcm_pkg
module bcm_fifo #(
   parameter int DEPTH = bcm_pkg::QUEUE_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  bcm_pkg::bcm_entry_type push_entry,
   output logic                   full,
   input  logic                   pop,
   output logic                   pop_valid,
   output bcm_pkg::bcm_entry_type pop_entry
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   bcm_pkg::bcm_entry_type slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   always_comb begin
      full      = (count_ff == CNT_W'(DEPTH));
      pop_valid = (count_ff != '0);
      pop_entry = slot_ff[rd_ptr_ff];
      do_push   = push && !full;
      do_pop    = pop && pop_valid;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

@@ rtl/core/bcm_front.sv @@
// front end: threshold register, request acceptance and classification
// depends on bcm_pkg; feeds bcm_fifo
module bcm_front (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  bcm_pkg::bcm_req_type                  req_data,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic signed [bcm_pkg::SAMPLE_BITS-1:0] csr_wdata,
   input  logic                                  q_full,
   output logic                                  q_push,
   output bcm_pkg::bcm_entry_type                q_entry
);

   logic signed [bcm_pkg::SAMPLE_BITS-1:0] thresh_ff, thresh_in;
   logic pred_pos, targ_pos;

   always_comb begin
      csr_ready = 1'b1;
      thresh_in = (csr_valid) ? csr_wdata : thresh_ff;
      req_ready = !q_full;
      q_push    = req_valid && !q_full;
      pred_pos  = ($signed(req_data.prediction) >= $signed(thresh_ff));
      targ_pos  = ($signed(req_data.target) >= $signed(bcm_pkg::TARGET_HALF));
      if (pred_pos && targ_pos) begin
         q_entry.cls = bcm_pkg::CLS_TP;
      end else if (pred_pos) begin
         q_entry.cls = bcm_pkg::CLS_FP;
      end else if (targ_pos) begin
         q_entry.cls = bcm_pkg::CLS_FN;
      end else begin
         q_entry.cls = bcm_pkg::CLS_TN;
      end
      q_entry.last = req_data.last_sample;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= bcm_pkg::THRESH_RESET;
      end else begin
         thresh_ff <= thresh_in;
      end
   end

endmodule

@@ rtl/core/bcm_div.sv @@
// bit-serial restoring divider for the Q1.16 ratios, one quotient bit a cycle
// depends on bcm_pkg; numerator never exceeds the denominator
module bcm_div #(
   parameter int DEN_W = 19
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [DEN_W-1:0]          num,
   input  logic [DEN_W-1:0]          den,
   output logic                      done,
   output logic [bcm_pkg::OUT_W-1:0] quot
);

   localparam int STEP_W = $clog2(bcm_pkg::FRAC_BITS + 1);

   logic                      busy_ff, busy_in;
   logic                      done_ff, done_in;
   logic [STEP_W-1:0]         step_ff, step_in;
   logic [DEN_W-1:0]          rem_ff, rem_in;
   logic [DEN_W-1:0]          den_ff, den_in;
   logic [bcm_pkg::OUT_W-1:0] quot_ff, quot_in;
   logic [DEN_W:0]            shifted, diff;
   logic                      ge;

   always_comb begin
      shifted = (step_ff == '0) ? {1'b0, rem_ff} : {rem_ff, 1'b0};
      diff    = shifted - {1'b0, den_ff};
      ge      = (shifted >= {1'b0, den_ff});
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quot_in = quot_ff;
      if (start) begin
         rem_in  = num;
         den_in  = den;
         step_in = '0;
         quot_in = '0;
         if (den == '0) begin
            done_in = 1'b1;
         end else begin
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         rem_in  = ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
         quot_in = {quot_ff[bcm_pkg::OUT_W-2:0], ge};
         if (step_ff == STEP_W'(bcm_pkg::FRAC_BITS)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quot_ff <= quot_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

@@ rtl/core/bcm_back.sv @@
// back end: saturating counters, end-of-set snapshot, ratio sequencer, result register
// depends on bcm_pkg and bcm_div
module bcm_back #(
   parameter int MAX_SAMPLES = bcm_pkg::MAX_SAMPLES
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_valid,
   input  bcm_pkg::bcm_entry_type q_entry,
   output logic                   q_pop,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output bcm_pkg::bcm_rsp_type   rsp_data
);

   localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
   localparam int DEN_W = CNT_W + 2;

   bcm_pkg::bcm_state_type state_ff, state_in;
   bcm_pkg::bcm_ratio_type ratio_ff, ratio_in;
   bcm_pkg::bcm_rsp_type   rsp_ff;

   logic [CNT_W-1:0] cnt_ff [4];
   logic [CNT_W-1:0] cnt_in [4];
   logic [CNT_W-1:0] cnt_next [4];
   logic [CNT_W-1:0] snap_ff [4];
   logic [CNT_W-1:0] snap_in [4];

   logic                      last_ok, pop, div_start, div_done;
   logic [DEN_W-1:0]          tp_w, fp_w, fn_w, tn_w, div_num, div_den;
   logic [bcm_pkg::OUT_W-1:0] div_quot;

   // outputs of the sequencer
   always_comb begin
      last_ok   = (state_ff == bcm_pkg::ST_IDLE);
      pop       = q_valid && (!q_entry.last || last_ok);
      q_pop     = pop;
      div_start = (state_ff == bcm_pkg::ST_LOAD);
      rsp_valid = (state_ff == bcm_pkg::ST_SEND);
   end

   // next state of the sequencer
   always_comb begin
      state_in = state_ff;
      ratio_in = ratio_ff;
      case (state_ff)
         bcm_pkg::ST_IDLE: begin
            if (pop && q_entry.last) begin
               state_in = bcm_pkg::ST_LOAD;
               ratio_in = bcm_pkg::RAT_PREC;
            end
         end
         bcm_pkg::ST_LOAD: begin
            state_in = bcm_pkg::ST_WAIT;
         end
         bcm_pkg::ST_WAIT: begin
            if (div_done) begin
               if (ratio_ff == bcm_pkg::RAT_ACC) begin
                  state_in = bcm_pkg::ST_SEND;
               end else begin
                  state_in = bcm_pkg::ST_LOAD;
                  ratio_in = bcm_pkg::bcm_ratio_type'(ratio_ff + 2'd1);
               end
            end
         end
         bcm_pkg::ST_SEND: begin
            if (rsp_ready) begin
               state_in = bcm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bcm_pkg::ST_IDLE;
         end
      endcase
   end

   // counters and snapshot
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         cnt_next[i] = cnt_ff[i];
         if (q_entry.cls == bcm_pkg::bcm_class_type'(2'(i)) &&
             cnt_ff[i] != CNT_W'(MAX_SAMPLES)) begin
            cnt_next[i] = cnt_ff[i] + 1'b1;
         end
         cnt_in[i]  = cnt_ff[i];
         snap_in[i] = snap_ff[i];
         if (pop) begin
            if (q_entry.last) begin
               snap_in[i] = cnt_next[i];
               cnt_in[i]  = '0;
            end else begin
               cnt_in[i] = cnt_next[i];
            end
         end
      end
   end

   // divider operands
   always_comb begin
      tp_w = DEN_W'(snap_ff[bcm_pkg::CLS_TP]);
      fp_w = DEN_W'(snap_ff[bcm_pkg::CLS_FP]);
      fn_w = DEN_W'(snap_ff[bcm_pkg::CLS_FN]);
      tn_w = DEN_W'(snap_ff[bcm_pkg::CLS_TN]);
      case (ratio_ff)
         bcm_pkg::RAT_PREC: begin
            div_num = tp_w;
            div_den = tp_w + fp_w;
         end
         bcm_pkg::RAT_REC: begin
            div_num = tp_w;
            div_den = tp_w + fn_w;
         end
         bcm_pkg::RAT_F1: begin
            div_num = {tp_w[DEN_W-2:0], 1'b0};
            div_den = {tp_w[DEN_W-2:0], 1'b0} + fp_w + fn_w;
         end
         default: begin
            div_num = tp_w + tn_w;
            div_den = tp_w + fp_w + fn_w + tn_w;
         end
      endcase
   end

   bcm_div #(
      .DEN_W(DEN_W)
   ) u_div (
      .clock(clock),
      .reset(reset),
      .start(div_start),
      .num  (div_num),
      .den  (div_den),
      .done (div_done),
      .quot (div_quot)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bcm_pkg::ST_IDLE;
         ratio_ff <= bcm_pkg::RAT_PREC;
         for (int i = 0; i < 4; i++) begin
            cnt_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         ratio_ff <= ratio_in;
         for (int i = 0; i < 4; i++) begin
            cnt_ff[i] <= cnt_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 4; i++) begin
         snap_ff[i] <= snap_in[i];
      end
      if (last_ok && pop && q_entry.last) begin
         rsp_ff.true_pos  <= bcm_pkg::OUT_W'(cnt_next[bcm_pkg::CLS_TP]);
         rsp_ff.false_pos <= bcm_pkg::OUT_W'(cnt_next[bcm_pkg::CLS_FP]);
         rsp_ff.false_neg <= bcm_pkg::OUT_W'(cnt_next[bcm_pkg::CLS_FN]);
         rsp_ff.true_neg  <= bcm_pkg::OUT_W'(cnt_next[bcm_pkg::CLS_TN]);
      end
      if (state_ff == bcm_pkg::ST_WAIT && div_done) begin
         case (ratio_ff)
            bcm_pkg::RAT_PREC: rsp_ff.precision_ratio <= div_quot;
            bcm_pkg::RAT_REC:  rsp_ff.recall_ratio    <= div_quot;
            bcm_pkg::RAT_F1:   rsp_ff.f1_ratio        <= div_quot;
            default:           rsp_ff.accuracy_ratio  <= div_quot;
         endcase
      end
   end

   assign rsp_data = rsp_ff;

endmodule

@@ rtl/core/binary_confusion_metrics_core.sv @@
// Binary confusion metrics core. Requests (prediction, target, last_sample) are
// taken one per clock for as long as the four-entry queue between the front end
// and the counters has room; a request at the head of the queue is counted into
// the counter registers as it is popped. A request marked last is counted, its
// set's counts are frozen and the counters clear for the next set at once, so
// the following set streams on without a gap. The four ratios then go one after
// another through a single bit-serial divider, which skips the bit steps when the
// denominator is zero, and the result is offered once all four are done. A
// further request marked last waits in the queue until the previous result has
// been taken. No clearing pass.
// depends on bcm_pkg, bcm_front, bcm_fifo, bcm_back
module binary_confusion_metrics_core #(
   parameter int MAX_SAMPLES = bcm_pkg::MAX_SAMPLES,
   parameter int QUEUE_DEPTH = bcm_pkg::QUEUE_DEPTH
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  bcm_pkg::bcm_req_type                  req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output bcm_pkg::bcm_rsp_type                  rsp_data,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic signed [bcm_pkg::SAMPLE_BITS-1:0] csr_wdata
);

   logic                   q_full, q_push, q_valid, q_pop;
   bcm_pkg::bcm_entry_type push_entry, pop_entry;

   bcm_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_wdata(csr_wdata),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_entry  (push_entry)
   );

   bcm_fifo #(
      .DEPTH(QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_entry(push_entry),
      .full      (q_full),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_entry (pop_entry)
   );

   bcm_back #(
      .MAX_SAMPLES(MAX_SAMPLES)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_valid  (q_valid),
      .q_entry  (pop_entry),
      .q_pop    (q_pop),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

endmodule

@@ rtl/core/bcm_checker.sv @@
// port-level checks on the result channel of the confusion metrics core, and its bind
// depends on bcm_pkg and binary_confusion_metrics_core_assert.svh
`include "binary_confusion_metrics_core_assert.svh"

module bcm_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input bcm_pkg::bcm_rsp_type rsp_data
);

   logic rsp_stall, ratios_in_range, ratios_zero, no_true_pos, full_precision, no_false_pos;

   always_comb begin
      rsp_stall       = rsp_valid && !rsp_ready;
      ratios_in_range = (rsp_data.precision_ratio <= bcm_pkg::RATIO_ONE) &&
                        (rsp_data.recall_ratio <= bcm_pkg::RATIO_ONE) &&
                        (rsp_data.f1_ratio <= bcm_pkg::RATIO_ONE) &&
                        (rsp_data.accuracy_ratio <= bcm_pkg::RATIO_ONE);
      ratios_zero     = (rsp_data.precision_ratio == '0) && (rsp_data.recall_ratio == '0) &&
                        (rsp_data.f1_ratio == '0);
      no_true_pos     = rsp_valid && (rsp_data.true_pos == '0);
      no_false_pos    = rsp_valid && (rsp_data.true_pos != '0) && (rsp_data.false_pos == '0);
      full_precision  = (rsp_data.precision_ratio == bcm_pkg::RATIO_ONE);
   end

   `BCM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_data))

   `BCM_ASSERT_IMPLY(a_ratio_range, clock, reset, rsp_valid, ratios_in_range)

   `BCM_ASSERT_IMPLY(a_no_true_pos, clock, reset, no_true_pos, ratios_zero)

   `BCM_ASSERT_IMPLY(a_full_precision, clock, reset, no_false_pos, full_precision)

endmodule

bind binary_confusion_metrics_core bcm_checker u_bcm_checker (
   .clock    (clock),
   .reset    (reset),
   .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready),
   .rsp_data (rsp_data)
);
